[sv/rvdec_pkg.sv]
// Shared types and constants for the RV32IM instruction decoder.
`default_nettype none

package rvdec_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned OutDataWidth = 64;
    localparam int unsigned OutUserWidth = 4;

    // Major opcodes (instruction bits 6..0)
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // Accepted funct7 values for register-register ops
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    // System immediates and the upper bits 31..7 of ecall and ebreak
    localparam logic [11:0] IMM_ECALL    = 12'b000000000000;
    localparam logic [11:0] IMM_EBREAK   = 12'b000000000001;
    localparam logic [24:0] EBREAK_UPPER = 25'b0000000000010000000000000;
    localparam logic [24:0] ECALL_UPPER  = 25'b0;

    typedef enum logic [2:0] {
        CLS_I   = 3'd0,
        CLS_S   = 3'd1,
        CLS_B   = 3'd2,
        CLS_U   = 3'd3,
        CLS_J   = 3'd4,
        CLS_R   = 3'd5,
        CLS_SYS = 3'd6,
        CLS_UNK = 3'd7
    } format_class_t;

    typedef struct packed {
        logic [6:0]         opcode;
        format_class_t      format_class;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] immediate;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic               invalid;
    } decode_t;

endpackage

`default_nettype wire

[sv/rvdec_field_decode.sv]
// Combinational field extraction, immediate assembly and validity checks.
`default_nettype none

module rvdec_field_decode (
    input  wire logic [rvdec_pkg::InstrWidth-1:0] instr,
    output rvdec_pkg::decode_t                    result
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7_r;

    assign opc  = instr[6:0];
    assign f3   = instr[14:12];
    assign f7_r = instr[31:25];

    always_comb
    begin
        result              = '0;
        result.opcode       = opc;
        result.format_class = rvdec_pkg::CLS_UNK;
        result.invalid      = 1'b1;
        unique case (opc) inside
            rvdec_pkg::OPC_LOAD, rvdec_pkg::OPC_OPIMM, rvdec_pkg::OPC_JALR:
            begin
                result.format_class = rvdec_pkg::CLS_I;
                result.rd           = instr[11:7];
                result.rs1          = instr[19:15];
                result.immediate    = {{20{instr[31]}}, instr[31:20]};
                result.funct3       = f3;
                result.funct7       = {1'b0, instr[31:26]};
                result.invalid      = 1'b0;
            end
            rvdec_pkg::OPC_STORE:
            begin
                result.format_class = rvdec_pkg::CLS_S;
                result.rs1          = instr[19:15];
                result.rs2          = instr[24:20];
                result.immediate    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
                result.funct3       = f3;
                result.invalid      = (f3 > 3'd2);
            end
            rvdec_pkg::OPC_BRANCH:
            begin
                result.format_class = rvdec_pkg::CLS_B;
                result.rs1          = instr[19:15];
                result.rs2          = instr[24:20];
                result.immediate    = {{19{instr[31]}}, instr[31], instr[7],
                                       instr[30:25], instr[11:8], 1'b0};
                result.funct3       = f3;
                result.invalid      = (f3 == 3'd2) || (f3 == 3'd3);
            end
            rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC:
            begin
                result.format_class = rvdec_pkg::CLS_U;
                result.rd           = instr[11:7];
                result.immediate    = {instr[31:12], 12'b0};
                result.invalid      = 1'b0;
            end
            rvdec_pkg::OPC_JAL:
            begin
                result.format_class = rvdec_pkg::CLS_J;
                result.rd           = instr[11:7];
                result.immediate    = {{11{instr[31]}}, instr[31], instr[19:12],
                                       instr[20], instr[30:21], 1'b0};
                result.invalid      = 1'b0;
            end
            rvdec_pkg::OPC_OP:
            begin
                result.format_class = rvdec_pkg::CLS_R;
                result.rd           = instr[11:7];
                result.rs1          = instr[19:15];
                result.rs2          = instr[24:20];
                result.funct3       = f3;
                result.funct7       = f7_r;
                result.invalid      = (f7_r != rvdec_pkg::F7_BASE) &&
                                      (f7_r != rvdec_pkg::F7_ALT) &&
                                      (f7_r != rvdec_pkg::F7_MUL);
            end
            rvdec_pkg::OPC_SYSTEM:
            begin
                result.format_class = rvdec_pkg::CLS_SYS;
                result.immediate    = {20'b0, instr[31:20]};
                // only the exact ecall and ebreak words pass
                result.invalid      = !((instr[31:7] == rvdec_pkg::ECALL_UPPER) ||
                                        (instr[31:7] == rvdec_pkg::EBREAK_UPPER));
            end
            default:
            begin
                result.format_class = rvdec_pkg::CLS_UNK;
                result.invalid      = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/rvdec_out_stage.sv]
// Result register with valid/ready flow control toward the output stream.
`default_nettype none

module rvdec_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rvdec_pkg::decode_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rvdec_pkg::decode_t      out_data
);

    logic               valid_reg;
    logic               valid_next;
    rvdec_pkg::decode_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[sv/rv32im_instruction_decoder_core.sv]
// Top level of the RV32IM instruction decoder: input register, decode, result register.
`default_nettype none

// Decodes one RV32IM instruction word per transaction into opcode, format
// class, register fields, sign-extended immediate, funct3, funct7 and an
// invalid flag. It takes one instruction every cycle with no bubbles while the
// output stream is ready; each instruction passes the input register, then
// the decode logic and the result register. Backpressure on the output stream
// stalls the result register, and the input register once it holds one. A new
// instruction is still taken while a finished result waits, as long as the
// input register is empty or the result register is being drained in the same cycle.
module rv32im_instruction_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] instr_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] opcode, [11:7] rd, [16:12] rs1, [21:17] rs2, [53:22] immediate,
    // [56:54] funct3, [63:57] funct7
    output logic [63:0]      m_axis_tdata,
    output logic [3:0]       m_axis_tuser    // [2:0] format_class, [3] invalid
);

    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic [rvdec_pkg::InstrWidth-1:0]    instr_reg;
    logic                                stage_ready;
    rvdec_pkg::decode_t                  dec_result;
    rvdec_pkg::decode_t                  out_result;

    assign s_axis_tready = !in_valid_reg || stage_ready;
    assign in_valid_next = s_axis_tvalid || (in_valid_reg && !stage_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            instr_reg <= s_axis_tdata;
        end
    end

    rvdec_field_decode u_decode (
        .instr  (instr_reg),
        .result (dec_result)
    );

    rvdec_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (stage_ready),
        .in_data   (dec_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {out_result.funct7, out_result.funct3, out_result.immediate,
                           out_result.rs2, out_result.rs1, out_result.rd,
                           out_result.opcode};
    assign m_axis_tuser = {out_result.invalid, out_result.format_class};

    // an unknown opcode is always flagged
    a_unknown_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == rvdec_pkg::CLS_UNK) |-> m_axis_tuser[3])
        else $error("unknown opcode not flagged invalid");

    // register-register ops carry no immediate
    a_r_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == rvdec_pkg::CLS_R) |->
        (m_axis_tdata[53:22] == 32'b0))
        else $error("R-type result has nonzero immediate");

    // a transaction taken while the pipe can move reaches the input register
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted instruction lost at input register");

    // a valid system result is ecall or ebreak with no register fields
    a_sys_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == rvdec_pkg::CLS_SYS) && !m_axis_tuser[3] |->
        (m_axis_tdata[21:7] == 15'b0) && (m_axis_tdata[53:23] == 31'b0))
        else $error("valid system result has stray fields");

endmodule

`default_nettype wire
